// ===== design/ostt_pkg.sv =====
// Shared types, codes and constants of the one-shot timer table.
package ostt_pkg;

  // Field widths fixed by the item formats.
  localparam int KIND_W     = 2;
  localparam int TIME_W     = 32;
  localparam int SLOT_IDX_W = 4;
  localparam int REPORT_W   = 2;
  localparam int SLOT_NUM_W = 4;

  // Default table size and the cap on fired reports per poll.
  localparam int SLOTS_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;

  // Operation codes of an input item.
  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POLL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

  // Report codes of a result item.
  localparam logic [REPORT_W-1:0] REPORT_CREATED = 2'd0;
  localparam logic [REPORT_W-1:0] REPORT_FIRED   = 2'd1;
  localparam logic [REPORT_W-1:0] REPORT_FULL    = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;   // take the neighbor's contents
    logic load;    // store a new deadline and arm the slot
    logic clr;     // disarm the slot
  } cell_ctrl_t;

endpackage

// ===== design/ostt_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface ostt_in_if;
  import ostt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [TIME_W-1:0]     current_time;
  logic [TIME_W-1:0]     duration;
  logic [SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, output kind, output current_time, output duration,
                  output slot_index, input ready);
  modport sink   (input valid, input kind, input current_time, input duration,
                  input slot_index, output ready);
endinterface

interface ostt_out_if;
  import ostt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REPORT_W-1:0]   report;
  logic [SLOT_NUM_W-1:0] slot_number;
  logic                  last;

  modport source (output valid, output report, output slot_number, output last,
                  input ready);
  modport sink   (input valid, input report, input slot_number, input last,
                  output ready);
endinterface

// ===== design/ostt_cell.sv =====
// One timer slot: deadline and armed flag, shiftable toward its neighbor.
module ostt_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ostt_pkg::cell_ctrl_t       ctrl,
  input  logic [ostt_pkg::TIME_W-1:0] load_deadline,
  input  logic [ostt_pkg::TIME_W-1:0] nb_deadline,
  input  logic                       nb_active,
  output logic [ostt_pkg::TIME_W-1:0] deadline,
  output logic                       active
);
  import ostt_pkg::*;

  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic              active_r, active_nxt;

  // Shift has priority; load and clear only happen while the row is at rest.
  always_comb begin
    deadline_nxt = deadline_r;
    active_nxt   = active_r;
    if (ctrl.shift) begin
      deadline_nxt = nb_deadline;
      active_nxt   = nb_active;
    end else if (ctrl.load) begin
      deadline_nxt = load_deadline;
      active_nxt   = 1'b1;
    end else if (ctrl.clr) begin
      active_nxt   = 1'b0;
    end
  end

  // The deadline needs no reset; an unarmed slot never reads it.
  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign deadline = deadline_r;
  assign active   = active_r;

endmodule

// ===== design/one_shot_timer_table_core.sv =====
// Top level of the one-shot timer table: a rotating row of slot cells and its sequencer.
//
//  Channel  Direction  Fields                                        Handshake
//  in_ch    sink       kind, current_time, duration, slot_index      valid/ready
//  out_ch   source     report, slot_number, last                     valid/ready
//
// A poll rotates the row of cells once, one slot per cycle while no stalled result holds
// it, then releases the final fired report, if any, from the flush state. The head cell's
// deadline compare tests each slot as it comes round; a fired report waits in a one-entry
// holding register until the next one is found or the scan ends, which fixes its last bit.
// Reset clears the armed flags, the slot counter and the output valid flag at once.
// A stalled result register holds the scan when a further fired slot is found.
module one_shot_timer_table_core #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  ostt_in_if.sink     in_ch,
  ostt_out_if.source  out_ch
);
  import ostt_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int FCW  = $clog2(MAX_RESULTS + 1);

  state_t state_r, state_nxt;
  logic [CNTW-1:0]   used_count_r, used_count_nxt;
  logic [IDXW-1:0]   step_r, step_nxt;
  logic [FCW-1:0]    fired_cnt_r, fired_cnt_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IDXW-1:0]   pend_slot_r, pend_slot_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [REPORT_W-1:0]   out_report_r, out_report_nxt;
  logic [SLOT_NUM_W-1:0] out_slot_r, out_slot_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [TIME_W-1:0] cell_deadline [SLOTS];
  logic              cell_active   [SLOTS];
  logic [TIME_W-1:0] new_deadline;

  logic in_accept, out_free, hit, advance;
  logic create_wr, cancel_wr, shift_en;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign new_deadline = in_ch.current_time + in_ch.duration;

  // The head cell holds the slot under test; stop marking fired after the cap.
  assign hit = cell_active[0] && (cell_deadline[0] < now_r) &&
               (fired_cnt_r < FCW'(MAX_RESULTS));
  assign advance = !(hit && pend_v_r && !out_free);

  // Sequencer and result register.
  always_comb begin
    state_nxt      = state_r;
    used_count_nxt = used_count_r;
    step_nxt       = step_r;
    fired_cnt_nxt  = fired_cnt_r;
    now_nxt        = now_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_report_nxt = out_report_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    create_wr      = 1'b0;
    cancel_wr      = 1'b0;
    shift_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_ch.kind)
            KIND_CREATE: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (used_count_r == CNTW'(SLOTS)) begin
                out_report_nxt = REPORT_FULL;
                out_slot_nxt   = '0;
              end else begin
                create_wr      = 1'b1;
                out_report_nxt = REPORT_CREATED;
                out_slot_nxt   = SLOT_NUM_W'(used_count_r);
                used_count_nxt = used_count_r + CNTW'(1);
              end
            end
            KIND_POLL: begin
              state_nxt     = S_SCAN;
              step_nxt      = '0;
              fired_cnt_nxt = '0;
              pend_v_nxt    = 1'b0;
              now_nxt       = in_ch.current_time;
            end
            KIND_CANCEL: begin
              cancel_wr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (advance) begin
          shift_en = 1'b1;
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_report_nxt = REPORT_FIRED;
              out_slot_nxt   = SLOT_NUM_W'(pend_slot_r);
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = step_r;
            fired_cnt_nxt = fired_cnt_r + FCW'(1);
          end
          step_nxt = step_r + IDXW'(1);
          if (step_r == IDXW'(SLOTS - 1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_report_nxt = REPORT_FIRED;
          out_slot_nxt   = SLOT_NUM_W'(pend_slot_r);
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_count_r <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Scan bookkeeping and result payload.
  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    fired_cnt_r  <= fired_cnt_nxt;
    now_r        <= now_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_report_r <= out_report_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.report      = out_report_r;
  assign out_ch.slot_number = out_slot_r;
  assign out_ch.last        = out_last_r;

  // Row of slot cells; the head wraps to the tail, disarmed if it just fired.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_ctrl_t        ctrl;
    logic [TIME_W-1:0] nb_deadline;
    logic              nb_active;

    assign ctrl.shift = shift_en;
    assign ctrl.load  = create_wr && (used_count_r == CNTW'(i));
    assign ctrl.clr   = cancel_wr && (int'(in_ch.slot_index) == i);

    if (i == SLOTS - 1) begin : g_tail
      assign nb_deadline = cell_deadline[0];
      assign nb_active   = cell_active[0] && !hit;
    end else begin : g_body
      assign nb_deadline = cell_deadline[i+1];
      assign nb_active   = cell_active[i+1];
    end

    ostt_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .load_deadline (new_deadline),
      .nb_deadline   (nb_deadline),
      .nb_active     (nb_active),
      .deadline      (cell_deadline[i]),
      .active        (cell_active[i])
    );
  end

endmodule

// ===== design/ostt_checker.sv =====
// Port-level checks of the timer table, bound to the top level.
module ostt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [ostt_pkg::KIND_W-1:0]     in_kind,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ostt_pkg::REPORT_W-1:0]   out_report,
  input logic [ostt_pkg::SLOT_NUM_W-1:0] out_slot_number,
  input logic                            out_last
);
  import ostt_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A create item answers in the next cycle with one final result.
  a_create_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_CREATE) |=>
      out_valid && out_last &&
      (out_report == REPORT_CREATED || out_report == REPORT_FULL))
    else $error("create item did not produce its result");

  // A full report always names slot zero.
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report == REPORT_FULL) |-> (out_slot_number == '0))
    else $error("table full report with nonzero slot");

  // After a non-final fired report the poll is still running, or its final
  // report is already on offer.
  a_poll_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_report == REPORT_FIRED) && !out_last |=>
      !in_ready || (out_valid && out_last))
    else $error("input taken before the poll finished");

endmodule

bind one_shot_timer_table_core ostt_checker u_ostt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_report      (out_ch.report),
  .out_slot_number (out_ch.slot_number),
  .out_last        (out_ch.last)
);

// ===== sim/one_shot_timer_table_core_tb.sv =====
// Self-checking testbench for the one-shot timer table core.
`timescale 1ns / 100ps

module one_shot_timer_table_core_tb;
  import ostt_pkg::*;

  localparam int SLOTS       = SLOTS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 380;
  // Latency allowance: a full poll rotation plus the final report and margin.
  localparam int SETTLE_CYCLES = 2 * SLOTS + 10;

  // The one operation code that the block ignores.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [REPORT_W-1:0]   report;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic                  last;
  } timer_report_t;

  // Scoreboard: mirrors the timer table and holds the reports still owed by the block.
  class timer_table_scoreboard;
    logic [TIME_W-1:0] deadline [SLOTS];
    bit                armed [SLOTS];
    int unsigned       slots_used;
    timer_report_t     pending_reports [$];
    int unsigned       mismatch_count;

    function new();
      slots_used     = 0;
      mismatch_count = 0;
      foreach (armed[i]) begin
        armed[i]    = 1'b0;
        deadline[i] = '0;
      end
    endfunction

    task report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Update the table for one accepted item and queue the reports it causes.
    function void note_request(input logic [KIND_W-1:0] kind,
                               input logic [TIME_W-1:0] now,
                               input logic [TIME_W-1:0] dur,
                               input logic [SLOT_IDX_W-1:0] idx);
      timer_report_t r;
      int fired;
      fired = 0;
      case (kind)
        KIND_CREATE: begin
          r.last = 1'b1;
          if (slots_used >= SLOTS) begin
            r.report      = REPORT_FULL;
            r.slot_number = '0;
          end else begin
            deadline[slots_used] = now + dur;
            armed[slots_used]    = 1'b1;
            r.report      = REPORT_CREATED;
            r.slot_number = SLOT_NUM_W'(slots_used);
            slots_used++;
          end
          pending_reports.push_back(r);
        end
        KIND_POLL: begin
          // Scan used slots in order; strictly-below compare, no wrap handling.
          for (int i = 0; i < slots_used; i++) begin
            if (fired >= MAX_RESULTS) break;
            if (armed[i] && deadline[i] < now) begin
              armed[i]      = 1'b0;
              r.report      = REPORT_FIRED;
              r.slot_number = SLOT_NUM_W'(i);
              r.last        = 1'b0;
              pending_reports.push_back(r);
              fired++;
            end
          end
          if (fired > 0) pending_reports[$].last = 1'b1;
        end
        KIND_CANCEL: begin
          if (idx < SLOTS) armed[idx] = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest outstanding report.
    task check_report(input logic [REPORT_W-1:0] report,
                      input logic [SLOT_NUM_W-1:0] slot_number,
                      input logic last);
      timer_report_t exp;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result report=%0d slot=%0d last=%0b",
                                  report, slot_number, last));
      end else begin
        exp = pending_reports.pop_front();
        if (report !== exp.report)
          report_mismatch($sformatf("report %0d, expected %0d", report, exp.report));
        if (slot_number !== exp.slot_number)
          report_mismatch($sformatf("slot_number %0d, expected %0d",
                                    slot_number, exp.slot_number));
        if (last !== exp.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, exp.last));
      end
    endtask

    function int pending_count();
      return pending_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle = 1'b0;
  int unsigned cycle_count = 0;

  timer_table_scoreboard sb = new();

  ostt_in_if  in_ch();
  ostt_out_if out_ch();

  one_shot_timer_table_core #(.SLOTS(SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Run limit: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Monitor both channels at the rising edge, input first, so order is fixed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.kind, in_ch.current_time, in_ch.duration, in_ch.slot_index);
      if (out_ch.valid && out_ch.ready)
        sb.check_report(out_ch.report, out_ch.slot_number, out_ch.last);
    end
  end

  // Result side back-pressure, dropped during the no-idle stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 31);
    end
  end

  // Drive one item from a falling edge and return at the falling edge after acceptance.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [TIME_W-1:0] now,
                              input logic [TIME_W-1:0] dur,
                              input logic [SLOT_IDX_W-1:0] idx);
    if (!no_idle && $urandom_range(0, 99) < 31) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.current_time <= now;
    in_ch.duration     <= dur;
    in_ch.slot_index   <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding report has come back, then let the core settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] uptime;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] dur;
    int pick;

    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_CREATE;
    in_ch.current_time = '0;
    in_ch.duration     = '0;
    in_ch.slot_index   = '0;
    rst_n              = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ignored kind, operations on an empty table, wrap, equal deadline.
    send_request(KIND_UNUSED, '1, '1, '1);
    send_request(KIND_CANCEL, 32'd0, 32'd0, 4'd5);
    send_request(KIND_POLL, '1, 32'd0, 4'd0);
    send_request(KIND_CREATE, 32'd0, 32'd0, 4'd0);
    send_request(KIND_CREATE, 32'd100, '1, 4'd0);
    send_request(KIND_CREATE, '1, '1, 4'd15);
    send_request(KIND_CREATE, 32'd1000, 32'd50, 4'd0);
    send_request(KIND_POLL, 32'd0, 32'd0, 4'd0);
    send_request(KIND_POLL, 32'd99, 32'd0, 4'd0);
    send_request(KIND_CANCEL, 32'd0, 32'd0, 4'd3);
    send_request(KIND_POLL, '1, 32'd0, 4'd0);
    send_request(KIND_POLL, '1, 32'd0, 4'd0);
    send_request(KIND_CANCEL, 32'd0, 32'd0, 4'd15);
    send_request(KIND_CANCEL, 32'd0, 32'd0, 4'd0);

    // Random: a running uptime, mostly short timers so several expire per poll.
    uptime = 32'd2000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) wait_drained();
      no_idle = (n >= 200 && n < 280);
      uptime  = uptime + $urandom_range(0, 300);
      now     = ($urandom_range(0, 99) < 12) ? $urandom() : uptime;
      dur     = ($urandom_range(0, 99) < 20) ? $urandom() : $urandom_range(0, 2000);
      pick    = $urandom_range(0, 99);
      if (pick < 35)
        send_request(KIND_CREATE, now, dur, SLOT_IDX_W'($urandom_range(0, 15)));
      else if (pick < 72)
        send_request(KIND_POLL, now, $urandom(), SLOT_IDX_W'($urandom_range(0, 15)));
      else if (pick < 94)
        send_request(KIND_CANCEL, $urandom(), $urandom(),
                     SLOT_IDX_W'($urandom_range(0, 15)));
      else
        send_request(KIND_UNUSED, $urandom(), $urandom(),
                     SLOT_IDX_W'($urandom_range(0, 15)));
    end
    no_idle = 1'b0;

    // Drain: everything expected has come, then watch for stray results.
    wait_drained();
    if (sb.mismatch_count == 0 && sb.pending_count() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== one_shot_timer_table_core.f =====
design/ostt_pkg.sv
design/ostt_if.sv
design/ostt_cell.sv
design/one_shot_timer_table_core.sv
design/ostt_checker.sv
sim/one_shot_timer_table_core_tb.sv
